// ===== rtl/core/fskm_pkg.sv =====
// fskm_pkg: shared widths, types and the fixed-point sine series for the fsk frame modulator
package fskm_pkg;

  localparam int SAMPLE_W  = 7;
  localparam int CHAR_W    = 8;
  localparam int FRAME_LEN = 11;
  localparam int POS_W     = 4;

  // q28 fixed point
  localparam longint Q_ONE          = 64'sd268435456;
  localparam longint PI_Q           = 64'sd843314857;
  localparam longint TWO_PI_NUM     = 64'sd6283184;
  localparam longint ANGLE_DEN_UNIT = 64'sd1000000;
  localparam longint LEVEL_SCALE    = 64'sd2048;
  localparam longint LEVEL_DIV      = 64'sd41 * Q_ONE;
  localparam longint SAMPLE_MAX     = 64'sd99;

  localparam int TAYLOR_TERMS = 12;
  // (2k)(2k+1) for k = 1 .. 12
  localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
    64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
  };

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [FRAME_LEN-1:0] frame_t;
  typedef logic [POS_W-1:0]     pos_t;

  // taylor series to the x^25 term, each product truncated toward zero
  function automatic longint sine_q28(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) / Q_ONE;
    term = x;
    sum  = x;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = (term * x2) / Q_ONE;
      term = term / TAYLOR_DIV[k];
      term = -term;
      sum  = sum + term;
    end
    return sum;
  endfunction

endpackage

// ===== rtl/core/fskm_in_if.sv =====
// fskm_in_if: request channel carrying sample ticks and send requests
interface fskm_in_if;
  import fskm_pkg::*;

  logic    valid;
  logic    ready;
  logic    req_type;
  char_t   char_data;

  modport source (output valid, output req_type, output char_data, input ready);
  modport sink   (input valid, input req_type, input char_data, output ready);
endinterface

// ===== rtl/core/fskm_out_if.sv =====
// fskm_out_if: result channel carrying one dac sample and status per transaction
interface fskm_out_if;
  import fskm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    frame_done;
  logic    send_accepted;
  logic    busy_res;

  modport source (output valid, output sample, output frame_done, output send_accepted,
                  output busy_res, input ready);
  modport sink   (input valid, input sample, input frame_done, input send_accepted,
                  input busy_res, output ready);
endinterface

// ===== rtl/core/fsk_uart_frame_modulator_top.sv =====
// fsk_uart_frame_modulator_top: binary fsk modulator for a uart-style character frame
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    req_type, char_data
//  out_ch    out   valid / ready    sample, frame_done, send_accepted, busy_res
//
//  one transaction per clock when out_ch is not stalled: every input transaction
//  passes an input register and a result register, so its result is written to the
//  result register when the input register moves on and is held there until taken;
//  the sine rom lookup and symbol counters sit between them
//  rst_n is synchronous: counters, flags and both valid bits clear, mark tone idle
//  a stalled out_ch still lets one more transaction into the input register
//  before in_ch.ready drops
module fsk_uart_frame_modulator_top #(
  parameter int SAMPLES_PER_SYMBOL = 83
) (
  input  logic              clk,
  input  logic              rst_n,
  fskm_in_if.sink           in_ch,
  fskm_out_if.source        out_ch
);
  import fskm_pkg::*;

  localparam int             IdxW   = $clog2(SAMPLES_PER_SYMBOL);
  localparam longint         RomDen = ANGLE_DEN_UNIT * SAMPLES_PER_SYMBOL;
  localparam logic [IdxW:0]  SymLen = SAMPLES_PER_SYMBOL[IdxW:0];

  typedef sample_t rom_t [SAMPLES_PER_SYMBOL];

  // one sine cycle over a symbol, offset and scaled into the dac range
  function automatic rom_t build_rom();
    rom_t   rom;
    longint t;
    longint s;
    longint lvl;
    longint v;
    for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
      t = (TWO_PI_NUM * longint'(i) * Q_ONE) / RomDen;
      if (t > PI_Q) begin
        t = t - 2 * PI_Q;
      end
      s   = sine_q28(t);
      lvl = Q_ONE + s;
      if (lvl < 0) begin
        lvl = 0;
      end
      v = (lvl * LEVEL_SCALE) / LEVEL_DIV;
      if (v == 0) begin
        v = 1;
      end
      if (v > SAMPLE_MAX) begin
        v = SAMPLE_MAX;
      end
      rom[i] = v[SAMPLE_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  // start bit 0, data msb first, odd parity over data bits 6..0, stop bit 1
  function automatic frame_t make_frame(input char_t c);
    frame_t f;
    f = '0;
    for (int k = 0; k < CHAR_W; k++) begin
      f[1 + k] = c[CHAR_W - 1 - k];
    end
    f[CHAR_W + 1] = ~^c[CHAR_W-2:0];
    f[FRAME_LEN - 1] = 1'b1;
    return f;
  endfunction

  // input register
  logic    s1_valid_r;
  logic    s1_req_r;
  char_t   s1_char_r;

  // modulator state
  logic [IdxW-1:0] idx_r, idx_nxt;
  pos_t            pos_r, pos_nxt;
  logic            tx_r, tx_nxt;
  logic            pend_r, pend_nxt;
  char_t           pend_char_r, pend_char_nxt;
  frame_t          frame_r, frame_nxt;
  logic            space_r, space_nxt;

  // result register
  logic    out_valid_r;
  sample_t out_sample_r, out_sample_nxt;
  logic    out_done_r, out_done_nxt;
  logic    out_acc_r, out_acc_nxt;
  logic    out_busy_r, out_busy_nxt;

  logic            adv;
  logic [IdxW:0]   idx_dbl;
  logic [IdxW:0]   idx_inc;
  logic [IdxW-1:0] rom_addr;
  logic            sym_end;
  pos_t            pos_inc;

  // the input register moves on whenever the result register is free or being drained
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  // space tone reads every second entry, wrapping once past the symbol length
  assign idx_dbl  = {idx_r, 1'b0};
  assign rom_addr = !space_r ? idx_r :
                    (idx_dbl >= SymLen) ? IdxW'(idx_dbl - SymLen) : idx_dbl[IdxW-1:0];
  assign idx_inc  = {1'b0, idx_r} + {{IdxW{1'b0}}, 1'b1};
  assign sym_end  = (idx_inc == SymLen);
  assign pos_inc  = pos_r + pos_t'(1);

  always_comb begin
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    tx_nxt         = tx_r;
    pend_nxt       = pend_r;
    pend_char_nxt  = pend_char_r;
    frame_nxt      = frame_r;
    space_nxt      = space_r;
    out_sample_nxt = '0;
    out_done_nxt   = 1'b0;
    out_acc_nxt    = 1'b0;
    if (adv) begin
      if (s1_req_r) begin
        // a second request while one waits is refused
        if (!pend_r) begin
          pend_char_nxt = s1_char_r;
          pend_nxt      = 1'b1;
          out_acc_nxt   = 1'b1;
        end
      end else begin
        out_sample_nxt = SineRom[rom_addr];
        idx_nxt        = sym_end ? '0 : idx_inc[IdxW-1:0];
        if (sym_end) begin
          if (tx_r) begin
            if (pos_inc >= pos_t'(FRAME_LEN)) begin
              // stop bit finished: back to idle mark tone
              pos_nxt      = '0;
              tx_nxt       = 1'b0;
              space_nxt    = 1'b0;
              out_done_nxt = 1'b1;
            end else begin
              pos_nxt   = pos_inc;
              space_nxt = !frame_r[pos_inc];
            end
          end else if (pend_r) begin
            // idle symbol ended with a character waiting: start bit begins
            frame_nxt = make_frame(pend_char_r);
            pend_nxt  = 1'b0;
            tx_nxt    = 1'b1;
            pos_nxt   = '0;
            space_nxt = !frame_nxt[0];
          end
        end
      end
    end
    out_busy_nxt = tx_nxt || pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      pos_r       <= '0;
      tx_r        <= 1'b0;
      pend_r      <= 1'b0;
      space_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      tx_r    <= tx_nxt;
      pend_r  <= pend_nxt;
      space_r <= space_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_r  <= in_ch.req_type;
      s1_char_r <= in_ch.char_data;
    end
    pend_char_r <= pend_char_nxt;
    frame_r     <= frame_nxt;
    if (adv) begin
      out_sample_r <= out_sample_nxt;
      out_done_r   <= out_done_nxt;
      out_acc_r    <= out_acc_nxt;
      out_busy_r   <= out_busy_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = out_sample_r;
  assign out_ch.frame_done    = out_done_r;
  assign out_ch.send_accepted = out_acc_r;
  assign out_ch.busy_res      = out_busy_r;

endmodule

// ===== tb/fskm_tb_pkg.sv =====
// fskm_tb_pkg: request codes and the symbol length shared by the testbench files
`timescale 1ns / 100ps

package fskm_tb_pkg;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  // the block's default symbol length
  localparam int SYMBOL_TICKS = 83;

endpackage

// ===== tb/fskm_sample_check.sv =====
// fskm_sample_check: watches both channels, predicts every dac sample and compares
`timescale 1ns / 100ps

module fskm_sample_check #(
  parameter int SYMBOL_TICKS = 83
) (
  input  logic clk,
  input  logic rst_n,
  fskm_in_if   in_ch,
  fskm_out_if  out_ch,
  output int   failures,
  output int   outstanding,
  output int   frames_sent,
  output int   refused
);
  import fskm_pkg::*;
  import fskm_tb_pkg::*;

  typedef struct packed {
    sample_t sample;
    logic    frame_done;
    logic    send_accepted;
    logic    busy;
  } tone_result_t;

  localparam longint Q28    = 64'sd268435456;
  localparam longint PI_Q28 = 64'sd843314857;

  sample_t      tone_rom [128];
  logic [6:0]   tick_idx;
  pos_t         symbol_pos;
  logic         sending;
  logic         holding;
  char_t        held_char;
  frame_t       frame_word;
  logic         space;
  tone_result_t expected_samples [$];
  tone_result_t want;
  tone_result_t got;

  // q28 angle of entry i, folded to -pi..pi, taylor sine to x^25, then scaled to the dac
  function automatic sample_t tone_level(input int i);
    longint angle;
    longint x2;
    longint term;
    longint series;
    longint level;
    longint code;
    angle = (64'sd6283184 * longint'(i) * Q28) / (64'sd1000000 * longint'(SYMBOL_TICKS));
    if (angle > PI_Q28) angle = angle - 2 * PI_Q28;
    x2     = (angle * angle) / Q28;
    term   = angle;
    series = angle;
    for (int k = 1; k <= 12; k++) begin
      term   = (term * x2) / Q28;
      term   = term / longint'((2 * k) * (2 * k + 1));
      term   = -term;
      series = series + term;
    end
    level = Q28 + series;
    if (level < 0) level = 0;
    code = (level * 64'sd2048) / (64'sd41 * Q28);
    if (code == 0) code = 1;
    if (code > 99) code = 99;
    return sample_t'(code);
  endfunction

  // start 0, data msb first, odd parity over bits 6..0, stop 1
  function automatic frame_t build_frame(input char_t c);
    frame_t f;
    f[0] = 1'b0;
    for (int k = 0; k < 8; k++) f[1 + k] = c[7 - k];
    f[9]  = ~^c[6:0];
    f[10] = 1'b1;
    return f;
  endfunction

  function automatic tone_result_t modulate_step(input logic req, input char_t c);
    tone_result_t r;
    int           phase;
    int           rom_at;
    r = '0;
    if (req == REQ_SEND) begin
      if (!holding) begin
        held_char       = c;
        holding         = 1'b1;
        r.send_accepted = 1'b1;
      end
    end else begin
      phase    = int'(tick_idx) % SYMBOL_TICKS;
      rom_at   = space ? (2 * phase) % SYMBOL_TICKS : phase;
      r.sample = tone_rom[rom_at & 127];
      phase++;
      if (phase >= SYMBOL_TICKS) begin
        phase = 0;
        if (sending) begin
          symbol_pos = symbol_pos + pos_t'(1);
          if (symbol_pos >= pos_t'(FRAME_LEN)) begin
            symbol_pos   = '0;
            sending      = 1'b0;
            space        = 1'b0;
            r.frame_done = 1'b1;
          end else begin
            space = ~frame_word[symbol_pos];
          end
        end else if (holding) begin
          frame_word = build_frame(held_char);
          holding    = 1'b0;
          sending    = 1'b1;
          symbol_pos = '0;
          space      = ~frame_word[0];
        end
      end
      tick_idx = phase[6:0];
    end
    r.busy = sending | holding;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] sample check: %s", $time, msg);
    failures++;
  endtask

  initial begin
    failures    = 0;
    outstanding = 0;
    frames_sent = 0;
    refused     = 0;
    for (int i = 0; i < 128; i++) tone_rom[i] = tone_level(i);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_idx   = '0;
      symbol_pos = '0;
      sending    = 1'b0;
      holding    = 1'b0;
      held_char  = '0;
      frame_word = '0;
      space      = 1'b0;
      expected_samples.delete();
    end else begin
      // a result never belongs to the transaction taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample, out_ch.frame_done, out_ch.send_accepted, out_ch.busy_res};
        if (expected_samples.size() == 0) begin
          flag_error("result with nothing expected");
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample)
            flag_error($sformatf("sample got %0d want %0d", got.sample, want.sample));
          if (got.frame_done !== want.frame_done)
            flag_error($sformatf("frame_done got %b want %b", got.frame_done, want.frame_done));
          if (got.send_accepted !== want.send_accepted)
            flag_error($sformatf("send_accepted got %b want %b",
                                 got.send_accepted, want.send_accepted));
          if (got.busy !== want.busy)
            flag_error($sformatf("busy_res got %b want %b", got.busy, want.busy));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = modulate_step(in_ch.req_type, in_ch.char_data);
        if (want.frame_done) frames_sent++;
        if (in_ch.req_type == REQ_SEND && !want.send_accepted) refused++;
        expected_samples.push_back(want);
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: stimulus and verdict for the fsk frame modulator, checking done beside the block
`timescale 1ns / 100ps

module testbench;
  import fskm_pkg::*;
  import fskm_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 500;

  logic clk;
  logic rst_n;

  fskm_in_if  in_ch ();
  fskm_out_if out_ch ();

  int mismatches;
  int outstanding;
  int frames_sent;
  int refused;
  int items_sent;
  int ticks_sent;
  int requests_sent;
  int quiet_cycles;
  bit calm;   // both sides run without gaps while set

  fsk_uart_frame_modulator_top #(
    .SAMPLES_PER_SYMBOL(SYMBOL_TICKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fskm_sample_check #(
    .SYMBOL_TICKS(SYMBOL_TICKS)
  ) sample_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .failures    (mismatches),
    .outstanding (outstanding),
    .frames_sent (frames_sent),
    .refused     (refused)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // characters at the corners of the byte turn up often, the rest at random
  function automatic char_t pick_char();
    int sel;
    sel = $urandom_range(0, 8);
    case (sel)
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      2: begin
        return 8'h80;
      end
      3: begin
        return 8'h7F;
      end
      4: begin
        return 8'h01;
      end
      default: begin
        return char_t'($urandom);
      end
    endcase
  endfunction

  // one transaction on the request channel: an optional gap with valid low, then valid held
  // until the block takes it; payload is noise during the gap
  task automatic offer_item(input logic req, input char_t ch);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid     = 1'b0;
      in_ch.req_type  = 1'($urandom);
      in_ch.char_data = char_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.req_type  = req;
    in_ch.char_data = ch;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (req == REQ_SEND) requests_sent++;
    else ticks_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // result side: a random stall before each transaction, then ready until one is taken
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // ends the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int scenes;
    int run_len;
    int mid_at;
    int late_at;
    int noise_len;
    bit late_on;
    quiet_cycles    = 0;
    items_sent      = 0;
    ticks_sent      = 0;
    requests_sent   = 0;
    scenes          = 0;
    calm            = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_TICK;
    in_ch.char_data = '0;
    rst_n           = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: idle mark tone, a request for all zeros, a refused all ones, then ticks
    // into the start of that frame
    offer_item(REQ_TICK, 8'hFF);
    offer_item(REQ_TICK, 8'h00);
    offer_item(REQ_SEND, 8'h00);
    offer_item(REQ_SEND, 8'hFF);
    repeat (2 * SYMBOL_TICKS) offer_item(REQ_TICK, char_t'($urandom));

    // random: mostly one request followed by enough ticks for a whole frame plus the idle
    // symbol before it, with extra requests dropped in at random points of that run; the rest is noise
    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        offer_item(REQ_SEND, pick_char());
        run_len = (FRAME_LEN + 1) * SYMBOL_TICKS + $urandom_range(0, 2 * SYMBOL_TICKS);
        mid_at  = $urandom_range(0, run_len - 1);
        late_at = $urandom_range(0, run_len - 1);
        late_on = 1'($urandom_range(0, 1));
        for (int k = 0; k < run_len; k++) begin
          if (k == mid_at) offer_item(REQ_SEND, pick_char());
          if (late_on && k == late_at) offer_item(REQ_SEND, pick_char());
          offer_item(REQ_TICK, char_t'($urandom));
        end
      end else begin
        noise_len = $urandom_range(1, 24);
        repeat (noise_len)
          offer_item(($urandom_range(0, 9) < 3) ? REQ_SEND : REQ_TICK, char_t'($urandom));
      end
      scenes++;
      // hold the sender back a couple of times until everything has come out
      if (scenes == 1 || scenes == 4) drain_results();
    end

    // wind down: everything out, then a short wait for stray results
    calm = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d ticks and %0d send requests (%0d refused)",
             ticks_sent, requests_sent, refused);
    $display("%0d frames went out at %0d samples per symbol", frames_sent, SYMBOL_TICKS);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fskm_pkg.sv
rtl/core/fskm_in_if.sv
rtl/core/fskm_out_if.sv
rtl/core/fsk_uart_frame_modulator_top.sv
tb/fskm_tb_pkg.sv
tb/fskm_sample_check.sv
tb/testbench.sv
